FILE: design/gte_cdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_cdc_pkg
// shared types and constants for the colour depth-cue block
// ----------------------------------------------------------------------------
package gte_cdc_pkg;

    localparam int FIFO_DEPTH = 3;

    localparam logic [2:0] CFG_MAT_R = 3'd0;
    localparam logic [2:0] CFG_MAT_G = 3'd1;
    localparam logic [2:0] CFG_MAT_B = 3'd2;
    localparam logic [2:0] CFG_BK    = 3'd3;
    localparam logic [2:0] CFG_FAR   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAT,
        ST_TERM,
        ST_FAR,
        ST_DONE,
        ST_OUT
    } t_state;

    // one multiply-accumulate request to the shared unit
    typedef struct packed {
        logic               clr;
        logic               en;
        logic signed [21:0] a;
        logic signed [16:0] b;
    } t_mac_req;

    typedef struct packed {
        logic signed [31:0] acc_one;
        logic signed [31:0] acc_two;
        logic signed [31:0] acc_three;
        logic [14:0]        out_one;
        logic [14:0]        out_two;
        logic [14:0]        out_three;
        logic [7:0]         pushed_red;
        logic [7:0]         pushed_green;
        logic [7:0]         pushed_blue;
        logic [7:0]         pushed_code;
        logic [5:0]         sat_flags;
    } t_result;

    typedef struct packed {
        logic signed [15:0] depth_weight;
        logic signed [15:0] vec_one;
        logic signed [15:0] vec_two;
        logic signed [15:0] vec_three;
        logic [7:0]         base_red;
        logic [7:0]         base_green;
        logic [7:0]         base_blue;
        logic [7:0]         base_code;
    } t_item;

endpackage

FILE: design/gte_cdc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_cdc_if
// valid/ready channel carrying one request payload
// ----------------------------------------------------------------------------
interface gte_cdc_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/gte_cdc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_cdc_mac
// shared multiply-accumulate unit, one product per cycle while i_req.en is set
// ----------------------------------------------------------------------------
module gte_cdc_mac
    import gte_cdc_pkg::*;
(
    input  logic               i_clk,
    input  t_mac_req           i_req,
    output logic signed [39:0] o_acc
);
    logic signed [39:0] r_acc;
    logic signed [38:0] w_prod;

    assign w_prod = 39'(i_req.a * i_req.b);

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_acc <= (i_req.clr ? 40'sd0 : r_acc) + 40'(w_prod);
        end
    end

    assign o_acc = r_acc;
endmodule

FILE: design/gte_color_depth_cue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_color_depth_cue_core
// colour depth-cue step with three-entry colour fifo
// ----------------------------------------------------------------------------
// usage:
//   configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) load the colour
//   matrix rows, background and far colour; the user must issue them only while
//   the core is idle (unenforced). s_in carries one request of IR0, IR1..IR3,
//   colour bytes and code. m_out returns one result request per input request.
// datapath and flow:
//   a single multiply-accumulate unit does the nine matrix products and the
//   three depth interpolations, the colour scalings use a small multiplier.
//   the next request is accepted the cycle after the result has been taken,
//   so only one request is in flight at a time.
// reset:
//   i_rst_n clears the configuration registers, the fifo and the sequencer.
// stall:
//   the result holds on m_out until ready; input stays blocked meanwhile.
// ----------------------------------------------------------------------------
module gte_color_depth_cue_core
    import gte_cdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [62:0] i_cfg_data,
    gte_cdc_if.sink     s_in,
    gte_cdc_if.source   m_out
);
    logic [47:0] r_mat [3];
    logic [62:0] r_bk, r_far;
    logic [31:0] r_fifo [FIFO_DEPTH];

    t_state r_state, n_state;
    logic [1:0] r_ch, n_ch;
    logic [1:0] r_k, n_k;
    t_item  r_item;
    logic signed [16:0] r_term;
    t_result r_res;

    t_mac_req w_req;
    logic signed [39:0] w_acc;
    logic signed [20:0] w_bk, w_far;
    logic signed [15:0] w_vec [3];
    logic [7:0] w_col;
    logic signed [39:0] w_m1, w_m2, w_diff;
    logic signed [15:0] w_cl;
    logic w_clf;

    gte_cdc_mac u_mac (.i_clk(i_clk), .i_req(w_req), .o_acc(w_acc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= '0; r_mat[1] <= '0; r_mat[2] <= '0;
            r_bk <= '0; r_far <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAT_R: r_mat[0] <= i_cfg_data[47:0];
                CFG_MAT_G: r_mat[1] <= i_cfg_data[47:0];
                CFG_MAT_B: r_mat[2] <= i_cfg_data[47:0];
                CFG_BK:    r_bk     <= i_cfg_data;
                CFG_FAR:   r_far    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_vec[0] = r_item.vec_one;
    assign w_vec[1] = r_item.vec_two;
    assign w_vec[2] = r_item.vec_three;
    assign w_bk  = r_bk[21*r_ch +: 21];
    assign w_far = r_far[21*r_ch +: 21];
    assign w_col = (r_ch == 2'd0) ? r_item.base_red :
                   (r_ch == 2'd1) ? r_item.base_green : r_item.base_blue;

    // sums on the accumulator result and the saturated far-colour difference
    assign w_m1   = 40'(w_bk) + (w_acc >>> 12);
    assign w_diff = 40'(w_far) - 40'(r_term);
    assign w_clf  = (w_diff < -40'sd32768) || (w_diff > 40'sd32767);
    assign w_cl   = (w_diff < -40'sd32768) ? -16'sd32768 :
                    (w_diff > 40'sd32767) ? 16'sd32767 : w_diff[15:0];
    assign w_m2   = 40'(r_term) + (w_acc >>> 12);

    always_comb begin
        n_state = r_state;
        n_ch = r_ch;
        n_k = r_k;
        w_req = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_in.valid) begin
                    n_state = ST_MAT; n_ch = '0; n_k = '0;
                end
            end
            ST_MAT: begin
                w_req.en = 1'b1;
                w_req.clr = (r_k == 2'd0);
                w_req.a = 22'($signed(r_mat[r_ch][16*r_k +: 16]));
                w_req.b = 17'(w_vec[r_k]);
                if (r_k == 2'd2) begin
                    n_k = '0; n_state = ST_TERM;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            ST_TERM: begin
                // accumulator holds the matrix sum
                n_state = ST_FAR;
            end
            ST_FAR: begin
                w_req.en = 1'b1;
                w_req.clr = 1'b1;
                w_req.a = 22'(r_item.depth_weight);
                w_req.b = 17'(w_cl);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (r_ch == 2'd2) begin
                    n_state = ST_OUT;
                end else begin
                    n_ch = r_ch + 2'd1; n_state = ST_MAT;
                end
            end
            ST_OUT: begin
                if (m_out.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // colour scaling from the saturated IR on a small multiplier
    logic signed [39:0] w_t;
    logic [14:0] w_irs;
    logic w_irf;
    assign w_irf = (w_m1 < 0) || (w_m1 > 40'sd32767);
    assign w_irs = (w_m1 < 0) ? 15'd0 : (w_m1 > 40'sd32767) ? 15'h7FFF : w_m1[14:0];
    assign w_t = 40'($signed({1'b0, w_col}) * $signed({1'b0, w_irs}));

    logic [1:0] w_ch;
    assign w_ch = r_ch;
    logic signed [35:0] w_s4;
    logic w_pf, w_if2;
    logic [7:0] w_px;
    logic [14:0] w_ir2;
    assign w_if2 = (w_m2 < 0) || (w_m2 > 40'sd32767);
    assign w_ir2 = (w_m2 < 0) ? 15'd0 : (w_m2 > 40'sd32767) ? 15'h7FFF : w_m2[14:0];
    assign w_s4 = 36'(w_m2 >>> 4);
    assign w_pf = (w_s4 < 0) || (w_s4 > 36'sd255);
    assign w_px = (w_s4 < 0) ? 8'd0 : (w_s4 > 36'sd255) ? 8'd255 : w_s4[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch <= '0;
            r_k <= '0;
            for (int i = 0; i < FIFO_DEPTH; i++) r_fifo[i] <= '0;
        end else begin
            r_state <= n_state;
            r_ch <= n_ch;
            r_k <= n_k;
            if (r_state == ST_OUT && m_out.ready) begin
                for (int i = 0; i < FIFO_DEPTH - 1; i++) r_fifo[i] <= r_fifo[i+1];
                r_fifo[FIFO_DEPTH-1] <= {r_res.pushed_code, r_res.pushed_blue,
                                         r_res.pushed_green, r_res.pushed_red};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_in.valid) begin
            r_item <= s_in.data;
            r_res.sat_flags <= '0;
        end
        if (r_state == ST_TERM) begin
            r_term <= 17'(w_t >>> 8);
            if (w_irf) r_res.sat_flags[5 - w_ch] <= 1'b1;
        end
        if (r_state == ST_FAR) begin
            if (w_clf) r_res.sat_flags[5 - w_ch] <= 1'b1;
        end
        if (r_state == ST_DONE) begin
            if (w_if2) r_res.sat_flags[5 - w_ch] <= 1'b1;
            if (w_pf) r_res.sat_flags[2 - w_ch] <= 1'b1;
            r_res.pushed_code <= r_item.base_code;
            unique case (w_ch)
                2'd0: begin r_res.acc_one <= w_m2[31:0]; r_res.out_one <= w_ir2;
                            r_res.pushed_red <= w_px; end
                2'd1: begin r_res.acc_two <= w_m2[31:0]; r_res.out_two <= w_ir2;
                            r_res.pushed_green <= w_px; end
                default: begin r_res.acc_three <= w_m2[31:0]; r_res.out_three <= w_ir2;
                            r_res.pushed_blue <= w_px; end
            endcase
        end
    end

    assign m_out.data  = r_res;
    assign m_out.valid = (r_state == ST_OUT);
    assign s_in.ready  = (r_state == ST_IDLE);

`ifndef SYNTH
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_in.ready && m_out.valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid) else $error("result dropped");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.valid && s_in.ready |=> r_state == ST_MAT) else $error("no start");
`endif
endmodule
